>>> sv/ibm97_pkg.sv
// Package for the IBAN mod-97 checker.
// Character codes, format constants, the classified item and the verdict codes.
// No dependencies.
package ibm97_pkg;

    localparam int unsigned IbanLen   = 27;
    localparam int unsigned CountSat  = 28;
    localparam int unsigned Modulus   = 97;
    localparam int unsigned CountW    = 5;
    localparam int unsigned LetterOfs = 10;

    // "F" (15) and "R" (27) folded behind the body: each fold of two digits is x3 mod 97
    localparam int unsigned TailFold  = (15 * 9 + 27 * 3) % Modulus;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChF     = 8'h46;
    localparam logic [7:0] ChR     = 8'h52;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChA     = 8'h41;
    localparam logic [7:0] ChZ     = 8'h5A;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_DIGIT,
        KIND_UPPER,
        KIND_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] value;   // digit 0..9 or letter 10..35
        logic       is_f;
        logic       is_r;
        logic       last;
    } t_item;

    typedef enum logic [1:0] {
        VERDICT_EMPTY   = 2'd0,
        VERDICT_VALID   = 2'd1,
        VERDICT_INVALID = 2'd2
    } t_verdict;

endpackage

>>> sv/ibm97_if.sv
// Valid/ready channel interfaces for the IBAN mod-97 checker.
// Character input channel and verdict output channel; no dependencies.
interface ibm97_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       has_char;
    logic       is_last;

    modport source (output valid, output character, output has_char, output is_last,
                    input ready);
    modport sink   (input valid, input character, input has_char, input is_last,
                    output ready);
endinterface

interface ibm97_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

>>> sv/ibm97_front.sv
// Front end of the IBAN mod-97 checker: accepts characters and classifies them.
// Depends on ibm97_pkg and ibm97_in_if.
module ibm97_front
    import ibm97_pkg::*;
(
    ibm97_in_if.sink      i_char,
    input  logic          i_full,
    output logic          o_push,
    output t_item         o_item
);

    always_comb begin
        o_item.is_f = (i_char.character == ChF);
        o_item.is_r = (i_char.character == ChR);
        o_item.last = i_char.is_last;
        if (!i_char.has_char || i_char.character == ChSpace) begin
            o_item.kind  = KIND_SKIP;
            o_item.value = '0;
        end else if (i_char.character inside {[ChZero:ChNine]}) begin
            o_item.kind  = KIND_DIGIT;
            o_item.value = 6'(i_char.character - ChZero);
        end else if (i_char.character inside {[ChA:ChZ]}) begin
            o_item.kind  = KIND_UPPER;
            o_item.value = 6'(i_char.character - ChA + 8'(LetterOfs));
        end else begin
            o_item.kind  = KIND_OTHER;
            o_item.value = '0;
        end
    end

    assign i_char.ready = !i_full;
    assign o_push       = i_char.valid && !i_full;

endmodule

>>> sv/ibm97_fifo.sv
// Short queue of classified characters between front and back end.
// Depends on ibm97_pkg (t_item).
module ibm97_fifo
    import ibm97_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_data,
    input  logic  i_pop
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/ibm97_back.sv
// Back end of the IBAN mod-97 checker: format tracking, running mod-97 remainder,
// final fold and verdict output register. Depends on ibm97_pkg and ibm97_out_if.
module ibm97_back
    import ibm97_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_item         i_item,
    output logic          o_pop,
    ibm97_out_if.source   o_res
);

    localparam int unsigned MaxQuot = (10 * (Modulus - 1) + 9) / Modulus;
    localparam int unsigned FinQuot = (27 * (Modulus - 1) + 99 + TailFold) / Modulus;

    typedef struct packed {
        logic       empty;
        logic       bad;
        logic [6:0] rem;
        logic [6:0] chk;
    } t_final;

    // Reduce a value below ten times the modulus
    function automatic logic [6:0] mod97(input logic [9:0] x);
        logic [9:0] sub;
        sub = '0;
        for (int k = 1; k <= MaxQuot; k++) begin
            if (x >= 10'(k * Modulus)) begin
                sub = 10'(k * Modulus);
            end
        end
        return 7'(x - sub);
    endfunction

    logic [CountW-1:0] r_count, n_count;
    logic              r_fmt_good, n_fmt_good;
    logic [6:0]        r_rem, n_rem;
    logic [6:0]        r_chk, n_chk;
    logic [6:0]        upd_rem;
    logic [6:0]        upd_chk;
    logic              upd_fmt;
    logic [CountW-1:0] upd_count;

    t_final            r_fin;
    logic              r_fin_valid;
    logic              r_out_valid;
    t_verdict          r_out_verdict;
    t_verdict          fin_verdict;
    logic [11:0]       fin_sum;
    logic              fin_hit;
    logic              out_take, fin_move, fin_free, take_last;

    assign out_take  = !r_out_valid || o_res.ready;
    assign fin_move  = r_fin_valid && out_take;
    assign fin_free  = !r_fin_valid || out_take;
    assign o_pop     = i_valid && (!i_item.last || fin_free);
    assign take_last = o_pop && i_item.last;

    // Character update
    always_comb begin
        upd_count = r_count;
        upd_fmt   = r_fmt_good;
        upd_rem   = r_rem;
        upd_chk   = r_chk;
        if (o_pop && i_item.kind != KIND_SKIP && r_count < CountW'(CountSat)) begin
            upd_count = r_count + 1'b1;
            if (r_count < CountW'(IbanLen)) begin
                case (r_count)
                    CountW'(0): begin
                        if (!i_item.is_f) upd_fmt = 1'b0;
                    end
                    CountW'(1): begin
                        if (!i_item.is_r) upd_fmt = 1'b0;
                    end
                    CountW'(2): begin
                        if (i_item.kind == KIND_DIGIT) upd_chk = 7'(i_item.value) * 7'd10;
                        else upd_fmt = 1'b0;
                    end
                    CountW'(3): begin
                        if (i_item.kind == KIND_DIGIT) upd_chk = r_chk + 7'(i_item.value);
                        else upd_fmt = 1'b0;
                    end
                    default: begin
                        // r*100 is 3r modulo 97
                        if (i_item.kind == KIND_DIGIT) begin
                            upd_rem = mod97(10'(r_rem) * 10'd10 + 10'(i_item.value));
                        end else if (i_item.kind == KIND_UPPER) begin
                            upd_rem = mod97(10'(r_rem) * 10'd3 + 10'(i_item.value));
                        end else begin
                            upd_fmt = 1'b0;
                        end
                    end
                endcase
            end
        end
        // Drop all state after a verdict
        if (take_last) begin
            n_count    = '0;
            n_fmt_good = 1'b1;
            n_rem      = '0;
            n_chk      = '0;
        end else begin
            n_count    = upd_count;
            n_fmt_good = upd_fmt;
            n_rem      = upd_rem;
            n_chk      = upd_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_fmt_good <= 1'b1;
            r_rem      <= '0;
            r_chk      <= '0;
        end else begin
            r_count    <= n_count;
            r_fmt_good <= n_fmt_good;
            r_rem      <= n_rem;
            r_chk      <= n_chk;
        end
    end

    // Final stage: hold the text summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (take_last) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_fin.empty <= (upd_count == '0);
            r_fin.bad   <= (upd_count != CountW'(IbanLen)) || !upd_fmt;
            r_fin.rem   <= upd_rem;
            r_fin.chk   <= upd_chk;
        end
    end

    // Fold F, R and the check digits behind the body: 27r + 22 + chk, then test for 1 mod 97
    always_comb begin
        fin_sum = 12'(r_fin.rem) * 12'd27 + 12'(r_fin.chk) + 12'(TailFold);
        fin_hit = 1'b0;
        for (int k = 0; k <= FinQuot; k++) begin
            if (fin_sum == 12'(k * Modulus + 1)) fin_hit = 1'b1;
        end
        if (r_fin.empty) begin
            fin_verdict = VERDICT_EMPTY;
        end else if (r_fin.bad || !fin_hit) begin
            fin_verdict = VERDICT_INVALID;
        end else begin
            fin_verdict = VERDICT_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out_verdict <= fin_verdict;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.verdict = r_out_verdict;

`ifndef SYNTHESIS
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(CountSat))
        else $error("character count beyond saturation");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < 7'(Modulus))
        else $error("remainder not reduced");

    a_chk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk <= 7'd99)
        else $error("check digits out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_last |=> (r_count == '0) && r_fmt_good && (r_rem == '0) && r_fin_valid)
        else $error("state not cleared after end of text");

    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !out_take |=> r_fin_valid && $stable(r_fin))
        else $error("final stage lost while output stalled");
`endif

endmodule

>>> sv/iban_mod97_checker.sv
// Checks a French IBAN given one character per transaction. Spaces and bare end
// markers are skipped; the transaction with is_last set closes the text and yields one
// verdict: 0 for empty text, 1 for a valid French IBAN (FR, two check digits, 23
// uppercase letters or digits, mod-97 remainder 1), 2 otherwise. One character is
// taken every clock cycle while the verdict output does not stall; after the closing
// transaction is accepted, the verdict passes through the queue, the final fold stage
// and the output register. A new text may follow at once.
// Depends on ibm97_pkg, ibm97_if, ibm97_front, ibm97_fifo and ibm97_back.
module iban_mod97_checker
    import ibm97_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ibm97_in_if.sink      i_char,
    ibm97_out_if.source   o_res
);

    logic  front_push;
    t_item front_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  back_pop;

    ibm97_front u_front (
        .i_char  (i_char),
        .i_full  (q_full),
        .o_push  (front_push),
        .o_item  (front_item)
    );

    ibm97_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_item),
        .i_pop   (back_pop)
    );

    ibm97_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (back_pop),
        .o_res   (o_res)
    );

endmodule
